### sv/udp_port_demux_queues_top_macros.svh
// Assertion helpers for the port demultiplexer.
`ifndef UDP_PORT_DEMUX_QUEUES_TOP_MACROS_SVH
`define UDP_PORT_DEMUX_QUEUES_TOP_MACROS_SVH
// Assert that a condition implies a consequence in the same cycle.
`define UPDQ_ASSERT_IMP(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("%m: lbl failed");
// Assert that a condition implies a consequence in the next cycle.
`define UPDQ_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("%m: lbl failed");
`endif

### sv/updq_pkg.sv
package updq_pkg;
   localparam int PortBits = 16;
   localparam int HandleBits = 12;
   localparam logic [7:0] UdpProto = 8'd17;
   localparam logic [15:0] UdpHdr = 16'd8;

   typedef enum logic [1:0] {
      OP_BIND = 2'd0, OP_UNBIND = 2'd1, OP_DELIVER = 2'd2, OP_RECEIVE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_UNBOUND = 3'd1, ST_FULL = 3'd2, ST_NOT_UDP = 3'd3,
      ST_EMPTY = 3'd4, ST_TABLE_FULL = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_PROBE, BK_READ, BK_WAIT, BK_DRAIN
   } back_state_type;

   typedef struct packed {
      op_type                operation;
      logic [PortBits-1:0]   port;
      logic [7:0]            ip_protocol;
      logic [31:0]           source_ip;
      logic [15:0]           source_port;
      logic [15:0]           udp_length;
      logic [HandleBits-1:0] buffer_handle;
      logic [15:0]           max_length;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [31:0]           source_ip_out;
      logic [15:0]           source_port_out;
      logic [15:0]           length_out;
      logic [HandleBits-1:0] handle_out;
      logic                  free_buffer;
      logic                  last;
   } rsp_type;

   // Queue entry handed from front to back: request plus stored payload length.
   typedef struct packed {
      req_type     req;
      logic [15:0] pay_len;
   } cmd_type;
endpackage

### sv/udp_port_demux_queues_top.sv
// UDP port demultiplexer with a receive queue per bound port.
// A request passes the command queue, the idle state, a probe state per slot probed
// and the result register; a receive adds the read and wait states, and an unbind of n
// queued entries gives its n results back to back. The back end takes a new command
// only when idle; the front queue accepts requests until both its entries are full.
// Reset (synchronous, active high) frees every slot and empties the command queue.
module udp_port_demux_queues_top
   import updq_pkg::*;
#(
   parameter int PORT_SLOTS = 64,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);
   logic    cmd_valid, cmd_pop;
   cmd_type cmd;

   // Front: accept requests and queue them with their payload length in a short queue.
   updq_front u_front (
      .clock, .reset, .start, .busy, .req(req_item),
      .cmd_valid, .cmd, .cmd_pop
   );

   // Back: probe the slot table, update queues, emit result beats.
   // Results cannot be stalled: each is shown on rsp_strobe for exactly one cycle.
   updq_back #(
      .PORT_SLOTS(PORT_SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_back (
      .clock, .reset, .cmd_valid, .cmd, .cmd_pop,
      .rsp_strobe, .rsp(rsp_item)
   );
endmodule

### sv/updq_front.sv
module updq_front
   import updq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);
   // Two-entry command queue.
   cmd_type    q_ff [2];
   cmd_type    q_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in;
   logic       push;

   assign busy = (cnt_ff == 2'd2);
   assign push = start && !busy;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = q_ff[rd_ff];

   always_comb begin
      q_in.req = req;
      q_in.pay_len = (req.udp_length > UdpHdr) ? req.udp_length - UdpHdr : 16'd0;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, cmd_pop};
      rd_in = rd_ff ^ cmd_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rd_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
      end
      if (push) q_ff[rd_ff ^ cnt_ff[0]] <= q_in;
   end
endmodule

### sv/updq_back.sv
module updq_back
   import updq_pkg::*;
#(
   parameter int PORT_SLOTS = 64,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_strobe,
   output rsp_type rsp
);
   localparam int SB = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
   localparam int QB = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CB = $clog2(QUEUE_DEPTH + 1);
   localparam int EB = SB + QB;
   localparam int PB = $clog2(PORT_SLOTS + 1);
   localparam int ED = PORT_SLOTS << QB;
   localparam int LB = 16 + HandleBits;
   localparam int WB = PortBits + CB + QB;

   // Slot word: owner port, queued count, head index.
   logic            valid_ff [PORT_SLOTS];
   logic [WB-1:0]   slot_mem [PORT_SLOTS];
   logic [47:0]     src_mem  [ED];
   logic [LB-1:0]   lh_mem   [ED];

   back_state_type st_ff, st_in;
   cmd_type        c_ff;
   logic [SB-1:0]  s_ff, s_in;
   logic [PB-1:0]  n_ff, n_in;
   logic [CB-1:0]  k_ff, k_in;
   logic [WB-1:0]  slot_rd_ff;
   logic [WB-1:0]  slot_wdata;
   logic           slot_we;
   logic [PortBits-1:0] owner;
   logic [CB-1:0]  count;
   logic [QB-1:0]  head;
   logic [47:0]    src_rd_ff;
   logic [LB-1:0]  lh_rd_ff;
   logic [EB-1:0]  raddr, waddr;
   logic           ren, enq;
   rsp_type        r_ff, r_in;
   logic           rv_ff, rv_in;
   logic           hit, freep;
   logic [SB-1:0]  s_next;

   function automatic logic [QB-1:0] wrap(input logic [QB-1:0] h, input logic [CB-1:0] k);
      logic [CB:0] t;
      t = {1'b0, (CB)'(h)} + {1'b0, k};
      if (t >= (CB+1)'(QUEUE_DEPTH)) t = t - (CB+1)'(QUEUE_DEPTH);
      return t[QB-1:0];
   endfunction

   function automatic rsp_type mk(input status_type s, input logic [HandleBits-1:0] h,
                                  input logic f, input logic l);
      rsp_type r;
      r = '0;
      r.status = s; r.handle_out = h; r.free_buffer = f; r.last = l;
      return r;
   endfunction

   assign {owner, count, head} = slot_rd_ff;
   assign cmd_pop = (st_ff == BK_IDLE) && cmd_valid;
   assign rsp_strobe = rv_ff;
   assign rsp = r_ff;
   assign hit = valid_ff[s_ff] && owner == c_ff.req.port;
   assign freep = !valid_ff[s_ff];
   assign s_next = (s_ff == SB'(PORT_SLOTS - 1)) ? '0 : s_ff + 1'b1;
   assign waddr = {s_ff, wrap(head, count)};
   assign enq = (st_ff == BK_PROBE) && hit && c_ff.req.operation == OP_DELIVER &&
                c_ff.req.ip_protocol == UdpProto && count < CB'(QUEUE_DEPTH);

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         BK_IDLE:  if (cmd_valid) st_in = BK_PROBE;
         BK_PROBE: begin
            if (hit) begin
               if ((c_ff.req.operation == OP_UNBIND && count != '0) ||
                   (c_ff.req.operation == OP_RECEIVE && count != '0))
                  st_in = BK_READ;
               else st_in = BK_IDLE;
            end else if (freep || n_ff == PB'(PORT_SLOTS - 1)) st_in = BK_IDLE;
         end
         BK_READ:  st_in = BK_WAIT;
         BK_WAIT:  st_in = (c_ff.req.operation == OP_UNBIND && k_ff != count) ?
                           BK_WAIT : BK_DRAIN;
         BK_DRAIN: st_in = BK_IDLE;
         default:  st_in = BK_IDLE;
      endcase
   end

   // Outputs and read address.
   always_comb begin
      rv_in = 1'b0;
      r_in = r_ff;
      s_in = s_ff;
      n_in = n_ff;
      k_in = k_ff;
      ren = 1'b0;
      raddr = {s_ff, wrap(head, k_ff)};
      case (st_ff)
         BK_IDLE: begin
            s_in = SB'(cmd.req.port % PORT_SLOTS);
            n_in = '0;
            k_in = '0;
         end
         BK_PROBE: begin
            if (!hit && !freep) begin
               s_in = s_next;
               n_in = n_ff + 1'b1;
            end
            if (hit || freep || n_ff == PB'(PORT_SLOTS - 1)) begin
               case (c_ff.req.operation)
                  OP_BIND: begin
                     rv_in = 1'b1;
                     r_in = mk((hit || freep) ? ST_OK : ST_TABLE_FULL, '0, 1'b0, 1'b1);
                  end
                  OP_UNBIND: begin
                     rv_in = !(hit && count != '0);
                     r_in = mk(hit ? ST_OK : ST_UNBOUND, '0, 1'b0, 1'b1);
                  end
                  OP_DELIVER: begin
                     rv_in = 1'b1;
                     if (c_ff.req.ip_protocol != UdpProto)
                        r_in = mk(ST_NOT_UDP, c_ff.req.buffer_handle, 1'b1, 1'b1);
                     else if (!hit)
                        r_in = mk(ST_UNBOUND, c_ff.req.buffer_handle, 1'b1, 1'b1);
                     else if (count >= CB'(QUEUE_DEPTH))
                        r_in = mk(ST_FULL, c_ff.req.buffer_handle, 1'b1, 1'b1);
                     else r_in = mk(ST_OK, '0, 1'b0, 1'b1);
                  end
                  default: begin
                     rv_in = !(hit && count != '0);
                     r_in = mk(hit ? ST_EMPTY : ST_UNBOUND, '0, 1'b0, 1'b1);
                  end
               endcase
            end
         end
         BK_READ: begin
            ren = 1'b1;
            k_in = k_ff + 1'b1;
         end
         BK_WAIT: begin
            rv_in = 1'b1;
            if (c_ff.req.operation == OP_UNBIND) begin
               r_in = mk(ST_OK, lh_rd_ff[HandleBits-1:0], 1'b1, k_ff == count);
               ren = 1'b1;
               k_in = k_ff + 1'b1;
            end else begin
               r_in = mk(ST_OK, lh_rd_ff[HandleBits-1:0], 1'b1, 1'b1);
               r_in.source_ip_out = src_rd_ff[47:16];
               r_in.source_port_out = src_rd_ff[15:0];
               r_in.length_out = (lh_rd_ff[LB-1:HandleBits] > c_ff.req.max_length) ?
                                 c_ff.req.max_length : lh_rd_ff[LB-1:HandleBits];
            end
         end
         default: ;
      endcase
   end

   // Slot word update: claim on bind, count up on enqueue, advance head on receive.
   always_comb begin
      slot_we = 1'b0;
      slot_wdata = slot_rd_ff;
      if (st_ff == BK_PROBE && c_ff.req.operation == OP_BIND && freep) begin
         slot_we = 1'b1;
         slot_wdata = {c_ff.req.port, CB'(0), QB'(0)};
      end else if (enq) begin
         slot_we = 1'b1;
         slot_wdata = {owner, count + 1'b1, head};
      end else if (st_ff == BK_DRAIN && c_ff.req.operation != OP_UNBIND) begin
         slot_we = 1'b1;
         slot_wdata = {owner, count - 1'b1, wrap(head, CB'(1))};
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[s_ff] <= slot_wdata;
      slot_rd_ff <= slot_mem[s_in];
      if (ren) begin
         src_rd_ff <= src_mem[raddr];
         lh_rd_ff <= lh_mem[raddr];
      end
      if (enq) begin
         src_mem[waddr] <= {c_ff.req.source_ip, c_ff.req.source_port};
         lh_mem[waddr] <= {c_ff.pay_len, c_ff.req.buffer_handle};
      end
      if (cmd_pop) c_ff <= cmd;
      r_ff <= r_in;
      s_ff <= s_in;
      n_ff <= n_in;
      k_ff <= k_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE;
         rv_ff <= 1'b0;
         for (int i = 0; i < PORT_SLOTS; i++) valid_ff[i] <= 1'b0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
         if (st_ff == BK_PROBE) begin
            if (c_ff.req.operation == OP_BIND && freep) valid_ff[s_ff] <= 1'b1;
            if (c_ff.req.operation == OP_UNBIND && hit && count == '0)
               valid_ff[s_ff] <= 1'b0;
         end
         if (st_ff == BK_DRAIN && c_ff.req.operation == OP_UNBIND) valid_ff[s_ff] <= 1'b0;
      end
   end
endmodule

### sv/updq_checker.sv
`include "udp_port_demux_queues_top_macros.svh"
module updq_checker
   import updq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_item
);
   `UPDQ_ASSERT_IMP(a_status_range, clock, reset, rsp_strobe, rsp_item.status <= ST_TABLE_FULL)
   `UPDQ_ASSERT_IMP(a_ok_deliver_clean, clock, reset,
      rsp_strobe && rsp_item.status != ST_OK && rsp_item.status != ST_EMPTY &&
      rsp_item.status != ST_TABLE_FULL && rsp_item.free_buffer,
      rsp_item.last)
   `UPDQ_ASSERT_IMP(a_empty_nofree, clock, reset,
      rsp_strobe && rsp_item.status == ST_EMPTY, !rsp_item.free_buffer && rsp_item.last)
   `UPDQ_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_strobe && !busy)
endmodule

bind udp_port_demux_queues_top updq_checker u_checker (
   .clock, .reset, .busy, .rsp_strobe, .rsp_item
);

### dv/tb.sv
module tb
   import updq_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumSlots = 64;
   localparam int QDepth = 16;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   udp_port_demux_queues_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state: port table and per-slot FIFOs.
   logic        tbl_valid [NumSlots];
   logic [15:0] tbl_port [NumSlots];
   int          tbl_count [NumSlots];
   int          tbl_head [NumSlots];
   logic [31:0] q_ip [NumSlots][QDepth];
   logic [15:0] q_sport [NumSlots][QDepth];
   logic [15:0] q_len [NumSlots][QDepth];
   logic [11:0] q_handle [NumSlots][QDepth];

   rsp_type pending_rsp [$];
   int      mismatches = 0;
   logic    idle_ok = 1'b1;

   // Hand-typed rows for the directed part; want_valid marks a typed-in result.
   typedef struct {
      req_type r;
      logic    want_valid;
      rsp_type want;
   } row_type;

   function automatic rsp_type mk_rsp(status_type st, logic [11:0] h, logic fb, logic lst);
      rsp_type x;
      x = '0;
      x.status = st;
      x.handle_out = h;
      x.free_buffer = fb;
      x.last = lst;
      return x;
   endfunction

   function automatic int lookup_slot(logic [15:0] p);
      int s;
      for (int i = 0; i < NumSlots; i++) begin
         s = (p + i) % NumSlots;
         if (!tbl_valid[s]) return -1;
         if (tbl_port[s] == p) return s;
      end
      return -1;
   endfunction

   // Apply one beat to the table and queue its expected results.
   task automatic predict_demux(req_type r);
      int s, t, e, n;
      logic [15:0] len;
      rsp_type x;
      s = lookup_slot(r.port);
      case (r.operation)
         OP_BIND: begin
            if (s < 0) begin
               x = mk_rsp(ST_TABLE_FULL, '0, 1'b0, 1'b1);
               for (int i = 0; i < NumSlots; i++) begin
                  t = (r.port + i) % NumSlots;
                  if (!tbl_valid[t]) begin
                     tbl_valid[t] = 1'b1;
                     tbl_port[t] = r.port;
                     tbl_count[t] = 0;
                     tbl_head[t] = 0;
                     x = mk_rsp(ST_OK, '0, 1'b0, 1'b1);
                     break;
                  end
               end
               pending_rsp.push_back(x);
            end else begin
               pending_rsp.push_back(mk_rsp(ST_OK, '0, 1'b0, 1'b1));
            end
         end
         OP_UNBIND: begin
            if (s < 0) begin
               pending_rsp.push_back(mk_rsp(ST_UNBOUND, '0, 1'b0, 1'b1));
            end else begin
               n = tbl_count[s];
               for (int k = 0; k < n; k++) begin
                  e = (tbl_head[s] + k) % QDepth;
                  pending_rsp.push_back(mk_rsp(ST_OK, q_handle[s][e], 1'b1, k + 1 == n));
               end
               if (n == 0) pending_rsp.push_back(mk_rsp(ST_OK, '0, 1'b0, 1'b1));
               tbl_valid[s] = 1'b0;
               tbl_port[s] = '0;
               tbl_count[s] = 0;
               tbl_head[s] = 0;
            end
         end
         OP_DELIVER: begin
            if (r.ip_protocol != UdpProto) begin
               pending_rsp.push_back(mk_rsp(ST_NOT_UDP, r.buffer_handle, 1'b1, 1'b1));
            end else if (s < 0) begin
               pending_rsp.push_back(mk_rsp(ST_UNBOUND, r.buffer_handle, 1'b1, 1'b1));
            end else if (tbl_count[s] >= QDepth) begin
               pending_rsp.push_back(mk_rsp(ST_FULL, r.buffer_handle, 1'b1, 1'b1));
            end else begin
               e = (tbl_head[s] + tbl_count[s]) % QDepth;
               q_ip[s][e] = r.source_ip;
               q_sport[s][e] = r.source_port;
               q_len[s][e] = (r.udp_length > UdpHdr) ? r.udp_length - UdpHdr : '0;
               q_handle[s][e] = r.buffer_handle;
               tbl_count[s]++;
               pending_rsp.push_back(mk_rsp(ST_OK, '0, 1'b0, 1'b1));
            end
         end
         default: begin
            if (s < 0) begin
               pending_rsp.push_back(mk_rsp(ST_UNBOUND, '0, 1'b0, 1'b1));
            end else if (tbl_count[s] == 0) begin
               pending_rsp.push_back(mk_rsp(ST_EMPTY, '0, 1'b0, 1'b1));
            end else begin
               e = tbl_head[s];
               len = (q_len[s][e] > r.max_length) ? r.max_length : q_len[s][e];
               x = mk_rsp(ST_OK, q_handle[s][e], 1'b1, 1'b1);
               x.source_ip_out = q_ip[s][e];
               x.source_port_out = q_sport[s][e];
               x.length_out = len;
               pending_rsp.push_back(x);
               tbl_head[s] = (tbl_head[s] + 1) % QDepth;
               tbl_count[s]--;
            end
         end
      endcase
   endtask

   // Compare every strobed result against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", rsp_item);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_item !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: want %p got %p", want, rsp_item);
            end
         end
      end
   end

   // Drive one beat at a falling edge and hold it until accepted; start stays
   // high into the next beat unless the sender idles.
   task automatic send_beat(req_type r);
      if (idle_ok)
         while ($urandom_range(99) < 25) begin
            start <= 1'b0;
            @(negedge clock);
         end
      req_item <= r;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_demux(r);
      @(negedge clock);
   endtask

   function automatic req_type mk_req(op_type op, logic [15:0] p);
      req_type r;
      r = '0;
      r.operation = op;
      r.port = p;
      r.ip_protocol = UdpProto;
      return r;
   endfunction

   // Random beat, mostly aimed at a small set of ports so queues fill and drain.
   function automatic req_type rand_req();
      req_type r;
      logic [15:0] pool [6];
      pool = '{16'd5, 16'd69, 16'd133, 16'd7, 16'hFFFF, 16'd1000};
      r.operation = op_type'($urandom_range(3));
      r.port = ($urandom_range(9) < 8) ? pool[$urandom_range(5)] : 16'($urandom);
      r.ip_protocol = ($urandom_range(9) < 8) ? UdpProto : 8'($urandom);
      r.source_ip = $urandom;
      r.source_port = 16'($urandom);
      r.udp_length = ($urandom_range(3) == 0) ? 16'($urandom_range(10)) : 16'($urandom);
      r.buffer_handle = 12'($urandom);
      r.max_length = ($urandom_range(1) == 0) ? 16'($urandom) : 16'hFFFF;
      return r;
   endfunction

   row_type rows [$];

   initial begin
      row_type w;
      req_type r;
      for (int i = 0; i < NumSlots; i++) begin
         tbl_valid[i] = 1'b0; tbl_port[i] = '0; tbl_count[i] = 0; tbl_head[i] = 0;
      end
      // Directed table: extremes, every op, and the special cases.
      w.want_valid = 1'b1; w.want = mk_rsp(ST_UNBOUND, '0, 1'b0, 1'b1);
      w.r = mk_req(OP_RECEIVE, 16'hFFFF); rows.push_back(w);
      w.r = mk_req(OP_UNBIND, 16'd0); rows.push_back(w);
      w.want = mk_rsp(ST_OK, '0, 1'b0, 1'b1);
      w.r = mk_req(OP_BIND, 16'd0); rows.push_back(w);
      w.r = mk_req(OP_BIND, 16'd0); rows.push_back(w);          // already bound
      w.r = mk_req(OP_BIND, 16'd64); rows.push_back(w);         // probes to next slot
      w.want = mk_rsp(ST_EMPTY, '0, 1'b0, 1'b1);
      w.r = mk_req(OP_RECEIVE, 16'd0); rows.push_back(w);
      w.r = mk_req(OP_DELIVER, 16'd0); w.r.ip_protocol = 8'hFF;
      w.r.buffer_handle = 12'hFFF; w.want = mk_rsp(ST_NOT_UDP, 12'hFFF, 1'b1, 1'b1);
      rows.push_back(w);
      w.r = mk_req(OP_DELIVER, 16'd1); w.r.buffer_handle = 12'h001;
      w.want = mk_rsp(ST_UNBOUND, 12'h001, 1'b1, 1'b1); rows.push_back(w);
      w.want_valid = 1'b0;
      w.r = mk_req(OP_DELIVER, 16'd0); w.r.source_ip = 32'hFFFFFFFF;
      w.r.source_port = 16'hFFFF; w.r.udp_length = 16'hFFFF; w.r.buffer_handle = 12'hABC;
      rows.push_back(w);
      w.r.udp_length = 16'd3; w.r.source_ip = '0; w.r.source_port = '0;
      w.r.buffer_handle = 12'h000; rows.push_back(w);           // length floors at zero
      w.r = mk_req(OP_RECEIVE, 16'd0); w.r.max_length = 16'd100; rows.push_back(w);
      w.r.max_length = 16'hFFFF; rows.push_back(w);
      w.r = mk_req(OP_DELIVER, 16'd64); w.r.udp_length = 16'd8; w.r.buffer_handle = 12'h5A5;
      rows.push_back(w);
      w.r = mk_req(OP_UNBIND, 16'd0); rows.push_back(w);        // empty queue
      w.r = mk_req(OP_RECEIVE, 16'd64); rows.push_back(w);      // hidden behind freed slot
      w.r = mk_req(OP_UNBIND, 16'd64); rows.push_back(w);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         send_beat(rows[i].r);
         if (rows[i].want_valid && pending_rsp.size() > 0 &&
             pending_rsp[pending_rsp.size() - 1] !== rows[i].want) begin
            mismatches++;
            if (mismatches <= 10) $display("table row %0d disagrees: %p", i, rows[i].want);
         end
      end

      // Fill one queue past its depth, then drain it by unbind.
      send_beat(mk_req(OP_BIND, 16'd9));
      for (int i = 0; i < QDepth + 1; i++) begin
         r = mk_req(OP_DELIVER, 16'd9);
         r.udp_length = 16'($urandom); r.buffer_handle = 12'($urandom);
         r.source_ip = $urandom; r.source_port = 16'($urandom);
         send_beat(r);
      end
      send_beat(mk_req(OP_UNBIND, 16'd9));

      // Hold off until every expected result has come.
      start <= 1'b0;
      @(negedge clock);
      while (pending_rsp.size() != 0) @(negedge clock);

      // Fill the whole table, binds past the end fail as table full, then free a few.
      for (int i = 0; i <= NumSlots; i++) send_beat(mk_req(OP_BIND, 16'(1000 + i)));
      for (int i = 0; i < 8; i++) send_beat(mk_req(OP_UNBIND, 16'(1000 + i)));

      // Random part; the middle stretch runs without idling.
      for (int i = 0; i < 20; i++) begin
         idle_ok = !(i >= 6 && i < 14);
         send_beat(rand_req());
      end
      idle_ok = 1'b1;
      for (int i = 0; i < 6; i++) send_beat(mk_req(OP_UNBIND, 16'($urandom_range(3)*64+5)));

      start <= 1'b0;
      @(negedge clock);
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (80) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb: errors");
      $finish;
   end
endmodule

### udp_port_demux_queues_top.f
+incdir+sv
sv/updq_pkg.sv
sv/updq_front.sv
sv/updq_back.sv
sv/udp_port_demux_queues_top.sv
sv/updq_checker.sv
dv/tb.sv
